// File: sv/lcrwf_pkg.sv
// Shared types, register codes and sequencing constants for the clipped window fill unit.
package lcrwf_pkg;

	localparam int COORD_W     = 11;
	localparam int COLOR_W     = 16;
	localparam int CNT_W       = 17;
	localparam int QUEUE_DEPTH = 4;
	localparam int CRED_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int QIDX_W      = $clog2(QUEUE_DEPTH);

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Command modes
	localparam logic [2:0] MODE_PIXEL  = 3'd0;
	localparam logic [2:0] MODE_HLINE  = 3'd1;
	localparam logic [2:0] MODE_VLINE  = 3'd2;
	localparam logic [2:0] MODE_RECT   = 3'd3;
	localparam logic [2:0] MODE_ROTATE = 3'd4;

	// Panel registers
	localparam logic [7:0] REG_ENTRY  = 8'h03;
	localparam logic [7:0] REG_CUR_X  = 8'h20;
	localparam logic [7:0] REG_CUR_Y  = 8'h21;
	localparam logic [7:0] REG_GRAM   = 8'h22;
	localparam logic [7:0] REG_HSTART = 8'h50;
	localparam logic [7:0] REG_HEND   = 8'h51;
	localparam logic [7:0] REG_VSTART = 8'h52;
	localparam logic [7:0] REG_VEND   = 8'h53;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [3:0] step_t;

	// Emission steps: window, data, window restore
	localparam step_t STEP_HSTART   = 4'd0;
	localparam step_t STEP_HEND     = 4'd1;
	localparam step_t STEP_VSTART   = 4'd2;
	localparam step_t STEP_VEND     = 4'd3;
	localparam step_t STEP_CUR_X    = 4'd4;
	localparam step_t STEP_CUR_Y    = 4'd5;
	localparam step_t STEP_DATA     = 4'd6;
	localparam step_t STEP_R_HSTART = 4'd7;
	localparam step_t STEP_R_HEND   = 4'd8;
	localparam step_t STEP_R_VSTART = 4'd9;
	localparam step_t STEP_R_VEND   = 4'd10;
	localparam step_t STEP_R_CUR_X  = 4'd11;
	localparam step_t STEP_R_CUR_Y  = 4'd12;

	typedef enum logic [1:0] {
		OP_PIXEL,
		OP_FILL,
		OP_ROTATE
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [1:0]         rot;
		coord_t             ax1;
		coord_t             ax2;
		coord_t             ay1;
		coord_t             ay2;
		coord_t             cx;
		coord_t             cy;
		logic [COLOR_W-1:0] color;
		logic [CNT_W-1:0]   count;
	} cmd_t;

	function automatic logic [15:0] entry_mode(input logic [1:0] rot);
		logic [15:0] word;
		case (rot)
			2'd1:    word = 16'h1028;
			2'd2:    word = 16'h1000;
			2'd3:    word = 16'h1018;
			default: word = 16'h1030;
		endcase
		return word;
	endfunction

endpackage

// File: sv/lcd_clip_rotate_window_fill_unit.sv
// Top level of the clipped, rotated window fill unit with its configuration port.
//
// Each command accepted on start (while busy is low) is clipped to the logical
// screen and turned into a stream of panel register writes on the result ports,
// one item per clock while strobe is high; the receiver cannot stall, so every
// strobed item must be taken on that cycle. A pixel gives 3 items, a line or
// rectangle gives 13 (window, address counter, one flood item carrying colour
// and pixel count, then the full-screen window restore), apply-rotation gives
// 7, and a fully clipped, empty or unused command gives none. last marks the
// final item of each command. With nothing ahead of it, a command passes the
// clipping register, the mapping register, the queue and the output register
// before its first item is on the result ports; earlier commands still being
// emitted delay it further. Throughput is set by the emitter, which sends one
// item per cycle, so a stream of fills runs with no gaps between commands. A
// two-stage front end clips and maps coordinates and feeds a 4-entry command
// queue; busy rises when 4 commands are in flight or queued.
// The rotation register sits at byte address 0 of the APB port (2 bits, reset 0);
// write it only while the unit is idle.
module lcd_clip_rotate_window_fill_unit #(
	parameter int PANEL_WIDTH  = 240,
	parameter int PANEL_HEIGHT = 320
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// command
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           mode,
	input  logic signed [15:0]   x_pos,
	input  logic signed [15:0]   y_pos,
	input  logic signed [15:0]   span_w,
	input  logic signed [15:0]   span_h,
	input  logic [15:0]          color,
	// results
	output logic                 strobe,
	output logic                 kind,
	output logic [7:0]           reg_addr,
	output logic [15:0]          reg_data,
	output logic [16:0]          pixel_count,
	output logic                 last
);
	import lcrwf_pkg::*;

	logic       rotation_q;
	logic [1:0] rot_q;
	logic       cfg_wr;
	logic       push, pop, empty;
	cmd_t       push_cmd, head;

	// Single register: decode on the word address bit
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & ~paddr[2];
	assign prdata = paddr[2] ? 32'd0 : {30'd0, rot_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q      <= 2'd0;
			rotation_q <= 1'b0;
		end else if (cfg_wr) begin
			rot_q      <= pwdata[1:0];
			rotation_q <= pwdata[0];
		end
	end

	lcrwf_front #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rotation (rot_q),
		.start    (start),
		.busy     (busy),
		.mode     (mode),
		.x_pos    (x_pos),
		.y_pos    (y_pos),
		.span_w   (span_w),
		.span_h   (span_h),
		.color    (color),
		.pop      (pop),
		.push     (push),
		.push_cmd (push_cmd)
	);

	lcrwf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	lcrwf_back #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.head        (head),
		.pop         (pop),
		.strobe      (strobe),
		.kind        (kind),
		.reg_addr    (reg_addr),
		.reg_data    (reg_data),
		.pixel_count (pixel_count),
		.last        (last)
	);

	// Odd-rotation bit must track the full rotation register
	a_rot_shadow: assert property (@(posedge clk) disable iff (!arst_n)
		rotation_q == rot_q[0])
		else $error("rotation shadow bit out of step");

endmodule

// File: sv/lcrwf_front.sv
// Front end: accepts commands, clips them, maps to panel coordinates, pushes to the queue.
module lcrwf_front #(
	parameter int PANEL_WIDTH  = 240,
	parameter int PANEL_HEIGHT = 320
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           rotation,
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           mode,
	input  logic signed [15:0]   x_pos,
	input  logic signed [15:0]   y_pos,
	input  logic signed [15:0]   span_w,
	input  logic signed [15:0]   span_h,
	input  logic [15:0]          color,
	input  logic                 pop,
	output logic                 push,
	output lcrwf_pkg::cmd_t      push_cmd
);
	import lcrwf_pkg::*;

	localparam logic signed [17:0] W_S = 18'(PANEL_WIDTH);
	localparam logic signed [17:0] H_S = 18'(PANEL_HEIGHT);
	localparam coord_t WM1 = COORD_W'(PANEL_WIDTH - 1);
	localparam coord_t HM1 = COORD_W'(PANEL_HEIGHT - 1);

	logic [CRED_W-1:0] credits_q;
	logic              accept;

	logic                valid_s1;
	logic [2:0]          mode_s1;
	logic signed [15:0]  x_s1, y_s1, w_s1, h_s1;
	logic [COLOR_W-1:0]  color_s1;
	logic [1:0]          rot_s1;

	logic signed [17:0]  xs, ys, ww, hh, lw, lh, xe, ye;
	logic signed [17:0]  x1c, y1c, x2c, y2c, dx, dy;
	logic                keep, drop;
	op_t                 op_c;

	logic                valid_s2;
	op_t                 op_s2;
	logic [1:0]          rot_s2;
	coord_t              x1_s2, y1_s2, x2_s2, y2_s2, dx_s2, dy_s2;
	logic [COLOR_W-1:0]  color_s2;

	logic [2*COORD_W-1:0] prod;

	assign accept = start & ~busy;
	assign busy   = (credits_q == CRED_W'(QUEUE_DEPTH));
	assign drop   = valid_s1 & ~keep;

	// Count commands in flight or queued; release on drop or pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credits_q <= '0;
		end else begin
			credits_q <= credits_q + CRED_W'(accept) - CRED_W'(drop) - CRED_W'(pop);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1  <= mode;
			x_s1     <= x_pos;
			y_s1     <= y_pos;
			w_s1     <= span_w;
			h_s1     <= span_h;
			color_s1 <= color;
			rot_s1   <= rotation;
		end
	end

	// Clip against the logical screen
	always_comb begin
		xs = {{2{x_s1[15]}}, x_s1};
		ys = {{2{y_s1[15]}}, y_s1};
		ww = {{2{w_s1[15]}}, w_s1};
		hh = {{2{h_s1[15]}}, h_s1};
		lw = rot_s1[0] ? H_S : W_S;
		lh = rot_s1[0] ? W_S : H_S;
		case (mode_s1)
			MODE_PIXEL: begin
				ww = 18'sd1;
				hh = 18'sd1;
			end
			MODE_HLINE: hh = 18'sd1;
			MODE_VLINE: begin
				hh = ww;
				ww = 18'sd1;
			end
			default: ;
		endcase
		xe  = xs + ww - 18'sd1;
		ye  = ys + hh - 18'sd1;
		x1c = (xs < 18'sd0) ? 18'sd0 : xs;
		y1c = (ys < 18'sd0) ? 18'sd0 : ys;
		x2c = (xe >= lw) ? lw - 18'sd1 : xe;
		y2c = (ye >= lh) ? lh - 18'sd1 : ye;
		dx  = x2c - x1c + 18'sd1;
		dy  = y2c - y1c + 18'sd1;
		case (mode_s1)
			MODE_PIXEL, MODE_HLINE, MODE_VLINE, MODE_RECT: begin
				keep = !(ww <= 18'sd0 || hh <= 18'sd0 || xs >= lw || ys >= lh ||
					xe < 18'sd0 || ye < 18'sd0);
			end
			MODE_ROTATE: keep = 1'b1;
			default:     keep = 1'b0;
		endcase
		case (mode_s1)
			MODE_PIXEL:  op_c = OP_PIXEL;
			MODE_ROTATE: op_c = OP_ROTATE;
			default:     op_c = OP_FILL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1 & keep;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			op_s2    <= op_c;
			rot_s2   <= rot_s1;
			x1_s2    <= COORD_W'(x1c);
			y1_s2    <= COORD_W'(y1c);
			x2_s2    <= COORD_W'(x2c);
			y2_s2    <= COORD_W'(y2c);
			dx_s2    <= COORD_W'(dx);
			dy_s2    <= COORD_W'(dy);
			color_s2 <= color_s1;
		end
	end

	// Pixel count and panel-native mapping
	assign prod = (2*COORD_W)'(dx_s2) * (2*COORD_W)'(dy_s2);

	always_comb begin
		push_cmd.op    = op_s2;
		push_cmd.rot   = rot_s2;
		push_cmd.color = color_s2;
		push_cmd.count = (prod > (2*COORD_W)'(CNT_MAX)) ? CNT_MAX : CNT_W'(prod);
		case (rot_s2)
			2'd1: begin
				push_cmd.ax1 = WM1 - y2_s2;
				push_cmd.ax2 = WM1 - y1_s2;
				push_cmd.ay1 = x1_s2;
				push_cmd.ay2 = x2_s2;
				push_cmd.cx  = WM1 - y1_s2;
				push_cmd.cy  = x1_s2;
			end
			2'd2: begin
				push_cmd.ax1 = WM1 - x2_s2;
				push_cmd.ax2 = WM1 - x1_s2;
				push_cmd.ay1 = HM1 - y2_s2;
				push_cmd.ay2 = HM1 - y1_s2;
				push_cmd.cx  = WM1 - x1_s2;
				push_cmd.cy  = HM1 - y1_s2;
			end
			2'd3: begin
				push_cmd.ax1 = y1_s2;
				push_cmd.ax2 = y2_s2;
				push_cmd.ay1 = HM1 - x2_s2;
				push_cmd.ay2 = HM1 - x1_s2;
				push_cmd.cx  = y1_s2;
				push_cmd.cy  = HM1 - x1_s2;
			end
			default: begin
				push_cmd.ax1 = x1_s2;
				push_cmd.ax2 = x2_s2;
				push_cmd.ay1 = y1_s2;
				push_cmd.ay2 = y2_s2;
				push_cmd.cx  = x1_s2;
				push_cmd.cy  = y1_s2;
			end
		endcase
	end

	assign push = valid_s2;

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credits_q <= CRED_W'(QUEUE_DEPTH))
		else $error("command credit count above queue depth");

endmodule

// File: sv/lcrwf_queue.sv
// Short command queue between the front end and the emitter.
module lcrwf_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lcrwf_pkg::cmd_t      push_cmd,
	input  logic                 pop,
	output logic                 empty,
	output lcrwf_pkg::cmd_t      head
);
	import lcrwf_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QIDX_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CRED_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CRED_W'(push) - CRED_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < CRED_W'(QUEUE_DEPTH) || pop))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue underflow");

endmodule

// File: sv/lcrwf_back.sv
// Emitter: walks the queued command through its register writes, one item per cycle.
module lcrwf_back #(
	parameter int PANEL_WIDTH  = 240,
	parameter int PANEL_HEIGHT = 320
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 empty,
	input  lcrwf_pkg::cmd_t      head,
	output logic                 pop,
	output logic                 strobe,
	output logic                 kind,
	output logic [7:0]           reg_addr,
	output logic [15:0]          reg_data,
	output logic [16:0]          pixel_count,
	output logic                 last
);
	import lcrwf_pkg::*;

	localparam coord_t WM1 = COORD_W'(PANEL_WIDTH - 1);
	localparam coord_t HM1 = COORD_W'(PANEL_HEIGHT - 1);

	logic             fresh_q;
	step_t            step_q, cur_step, first_step, final_step;
	coord_t           rcx, rcy;
	logic             kind_d;
	logic [7:0]       addr_d;
	logic [15:0]      data_d;
	logic [CNT_W-1:0] count_d;

	logic             strobe_q, last_q, kind_q;
	logic [7:0]       addr_q;
	logic [15:0]      data_q;
	logic [CNT_W-1:0] count_q;

	always_comb begin
		case (head.op)
			OP_PIXEL:  first_step = STEP_CUR_X;
			OP_ROTATE: first_step = STEP_DATA;
			default:   first_step = STEP_HSTART;
		endcase
		final_step = (head.op == OP_PIXEL) ? STEP_DATA : STEP_R_CUR_Y;
		cur_step   = fresh_q ? first_step : step_q;
	end

	assign pop = ~empty & (cur_step == final_step);

	// Cursor of the full-screen window depends on rotation
	assign rcx = (head.rot == 2'd1 || head.rot == 2'd2) ? WM1 : '0;
	assign rcy = (head.rot == 2'd2 || head.rot == 2'd3) ? HM1 : '0;

	always_comb begin
		kind_d  = 1'b0;
		addr_d  = '0;
		data_d  = '0;
		count_d = '0;
		case (cur_step)
			STEP_HSTART: begin addr_d = REG_HSTART; data_d = 16'(head.ax1); end
			STEP_HEND:   begin addr_d = REG_HEND;   data_d = 16'(head.ax2); end
			STEP_VSTART: begin addr_d = REG_VSTART; data_d = 16'(head.ay1); end
			STEP_VEND:   begin addr_d = REG_VEND;   data_d = 16'(head.ay2); end
			STEP_CUR_X:  begin addr_d = REG_CUR_X;  data_d = 16'(head.cx);  end
			STEP_CUR_Y:  begin addr_d = REG_CUR_Y;  data_d = 16'(head.cy);  end
			STEP_DATA: begin
				case (head.op)
					OP_FILL: begin
						kind_d  = 1'b1;
						addr_d  = REG_GRAM;
						data_d  = head.color;
						count_d = head.count;
					end
					OP_PIXEL: begin
						addr_d = REG_GRAM;
						data_d = head.color;
					end
					default: begin
						addr_d = REG_ENTRY;
						data_d = entry_mode(head.rot);
					end
				endcase
			end
			STEP_R_HSTART: begin addr_d = REG_HSTART; data_d = '0;          end
			STEP_R_HEND:   begin addr_d = REG_HEND;   data_d = 16'(WM1);    end
			STEP_R_VSTART: begin addr_d = REG_VSTART; data_d = '0;          end
			STEP_R_VEND:   begin addr_d = REG_VEND;   data_d = 16'(HM1);    end
			STEP_R_CUR_X:  begin addr_d = REG_CUR_X;  data_d = 16'(rcx);    end
			STEP_R_CUR_Y:  begin addr_d = REG_CUR_Y;  data_d = 16'(rcy);    end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q  <= 1'b1;
			step_q   <= STEP_HSTART;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= ~empty;
			last_q   <= pop;
			if (!empty) begin
				if (pop) begin
					fresh_q <= 1'b1;
				end else begin
					fresh_q <= 1'b0;
					step_q  <= cur_step + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!empty) begin
			kind_q  <= kind_d;
			addr_q  <= addr_d;
			data_q  <= data_d;
			count_q <= count_d;
		end
	end

	assign strobe      = strobe_q;
	assign kind        = kind_q;
	assign reg_addr    = addr_q;
	assign reg_data    = data_q;
	assign pixel_count = count_q;
	assign last        = last_q;

	a_last_strobed: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> strobe)
		else $error("last flag without a result");

	a_flood_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && kind) |-> (reg_addr == REG_GRAM))
		else $error("flood item not aimed at GRAM");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		!fresh_q |-> (step_q <= STEP_R_CUR_Y))
		else $error("emitter step out of range");

endmodule

// File: tb/sv/panel_write_monitor.sv
`timescale 1ns / 1ps
// Monitor that predicts the panel write stream from accepted commands and checks every strobed item.
module panel_write_monitor
	import lcrwf_pkg::*;
#(
	parameter int         PANEL_WIDTH   = 240,
	parameter int         PANEL_HEIGHT  = 320,
	parameter logic [2:0] ROTATION_ADDR = 3'd0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	input  logic               start,
	input  logic               busy,
	input  logic [2:0]         mode,
	input  logic signed [15:0] x_pos,
	input  logic signed [15:0] y_pos,
	input  logic signed [15:0] span_w,
	input  logic signed [15:0] span_h,
	input  logic [15:0]        color,
	input  logic               strobe,
	input  logic               kind,
	input  logic [7:0]         reg_addr,
	input  logic [15:0]        reg_data,
	input  logic [16:0]        pixel_count,
	input  logic               last,
	output int                 errors,
	output int                 pending
);

	localparam logic KIND_REG   = 1'b0;
	localparam logic KIND_FLOOD = 1'b1;

	localparam logic [15:0] ENTRY_ROT0 = 16'h1030;
	localparam logic [15:0] ENTRY_ROT1 = 16'h1028;
	localparam logic [15:0] ENTRY_ROT2 = 16'h1000;
	localparam logic [15:0] ENTRY_ROT3 = 16'h1018;

	localparam int PRINT_CAP = 100;

	typedef struct packed {
		logic             kind;
		logic [7:0]       addr;
		logic [15:0]      data;
		logic [CNT_W-1:0] count;
		logic             last;
	} panel_write_t;

	panel_write_t expected_writes[$];
	logic [1:0]   rotation = 2'd0;
	int           mismatch_count = 0;
	int           queued = 0;

	assign errors  = mismatch_count;
	assign pending = queued;

	task automatic report_mismatch(input string what);
		// keep the log short if the stream goes badly wrong
		if (mismatch_count < PRINT_CAP)
			$display("[%0t] mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	function automatic void push_write(input logic k, input logic [7:0] a, input int d,
			input int unsigned c);
		panel_write_t w;
		w.kind  = k;
		w.addr  = a;
		w.data  = d[15:0];
		w.count = c[CNT_W-1:0];
		w.last  = 1'b0;
		expected_writes.push_back(w);
	endfunction

	// Map a logical window to panel-native coordinates and queue its six writes.
	function automatic void push_window(input int x1, input int y1, input int x2, input int y2);
		int ax1, ax2, ay1, ay2, cx, cy;
		case (rotation)
			2'd1: begin
				ax1 = PANEL_WIDTH - 1 - y2; ax2 = PANEL_WIDTH - 1 - y1;
				ay1 = x1; ay2 = x2;
				cx = ax2; cy = ay1;
			end
			2'd2: begin
				ax1 = PANEL_WIDTH - 1 - x2; ax2 = PANEL_WIDTH - 1 - x1;
				ay1 = PANEL_HEIGHT - 1 - y2; ay2 = PANEL_HEIGHT - 1 - y1;
				cx = ax2; cy = ay2;
			end
			2'd3: begin
				ax1 = y1; ax2 = y2;
				ay1 = PANEL_HEIGHT - 1 - x2; ay2 = PANEL_HEIGHT - 1 - x1;
				cx = ax1; cy = ay2;
			end
			default: begin
				ax1 = x1; ax2 = x2; ay1 = y1; ay2 = y2;
				cx = x1; cy = y1;
			end
		endcase
		push_write(KIND_REG, REG_HSTART, ax1, 0);
		push_write(KIND_REG, REG_HEND, ax2, 0);
		push_write(KIND_REG, REG_VSTART, ay1, 0);
		push_write(KIND_REG, REG_VEND, ay2, 0);
		push_write(KIND_REG, REG_CUR_X, cx, 0);
		push_write(KIND_REG, REG_CUR_Y, cy, 0);
	endfunction

	function automatic void predict_command(input logic [2:0] m, input logic signed [15:0] xs,
			input logic signed [15:0] ys, input logic signed [15:0] ws,
			input logic signed [15:0] hs, input logic [15:0] c);
		int           x, y, w, h, x2, y2, lw, lh, px, py, n0;
		longint       area;
		int unsigned  cnt;
		logic [15:0]  word;
		panel_write_t tail;
		x  = xs;
		y  = ys;
		w  = ws;
		h  = hs;
		lw = rotation[0] ? PANEL_HEIGHT : PANEL_WIDTH;
		lh = rotation[0] ? PANEL_WIDTH : PANEL_HEIGHT;
		n0 = expected_writes.size();
		case (m)
			MODE_PIXEL: begin
				if (x >= 0 && y >= 0 && x < lw && y < lh) begin
					case (rotation)
						2'd1:    begin px = PANEL_WIDTH - 1 - y; py = x; end
						2'd2:    begin px = PANEL_WIDTH - 1 - x; py = PANEL_HEIGHT - 1 - y; end
						2'd3:    begin px = y; py = PANEL_HEIGHT - 1 - x; end
						default: begin px = x; py = y; end
					endcase
					push_write(KIND_REG, REG_CUR_X, px, 0);
					push_write(KIND_REG, REG_CUR_Y, py, 0);
					push_write(KIND_REG, REG_GRAM, c, 0);
				end
			end
			MODE_HLINE, MODE_VLINE, MODE_RECT: begin
				if (m == MODE_HLINE) begin
					h = 1;
				end else if (m == MODE_VLINE) begin
					h = w;
					w = 1;
				end
				if (w > 0 && h > 0 && x < lw && y < lh) begin
					x2 = x + w - 1;
					y2 = y + h - 1;
					if (x2 >= 0 && y2 >= 0) begin
						if (x < 0) x = 0;
						if (y < 0) y = 0;
						if (x2 >= lw) x2 = lw - 1;
						if (y2 >= lh) y2 = lh - 1;
						area = longint'(x2 - x + 1) * longint'(y2 - y + 1);
						cnt  = (area > longint'(CNT_MAX)) ? int'(CNT_MAX) : int'(area);
						push_window(x, y, x2, y2);
						push_write(KIND_FLOOD, REG_GRAM, c, cnt);
						push_window(0, 0, lw - 1, lh - 1);
					end
				end
			end
			MODE_ROTATE: begin
				case (rotation)
					2'd1:    word = ENTRY_ROT1;
					2'd2:    word = ENTRY_ROT2;
					2'd3:    word = ENTRY_ROT3;
					default: word = ENTRY_ROT0;
				endcase
				push_write(KIND_REG, REG_ENTRY, word, 0);
				push_window(0, 0, lw - 1, lh - 1);
			end
			default: ;
		endcase
		if (expected_writes.size() > n0) begin
			tail = expected_writes.pop_back();
			tail.last = 1'b1;
			expected_writes.push_back(tail);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		panel_write_t want;
		if (!arst_n) begin
			rotation = 2'd0;
			expected_writes.delete();
			queued <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == ROTATION_ADDR)
				rotation = pwdata[1:0];
			if (start && !busy)
				predict_command(mode, x_pos, y_pos, span_w, span_h, color);
			if (strobe !== 1'b0) begin
				if (expected_writes.size() == 0) begin
					report_mismatch($sformatf("unexpected item addr %02h data %04h",
						reg_addr, reg_data));
				end else begin
					want = expected_writes.pop_front();
					if (kind !== want.kind)
						report_mismatch($sformatf("kind %b, want %b (addr %02h)",
							kind, want.kind, want.addr));
					if (reg_addr !== want.addr)
						report_mismatch($sformatf("reg_addr %02h, want %02h",
							reg_addr, want.addr));
					if (reg_data !== want.data)
						report_mismatch($sformatf("reg_data %04h, want %04h (addr %02h)",
							reg_data, want.data, want.addr));
					if (pixel_count !== want.count)
						report_mismatch($sformatf("pixel_count %0d, want %0d (addr %02h)",
							pixel_count, want.count, want.addr));
					if (last !== want.last)
						report_mismatch($sformatf("last %b, want %b (addr %02h)",
							last, want.last, want.addr));
				end
			end
			queued <= expected_writes.size();
		end
	end

endmodule

// File: tb/sv/tb_lcd_clip_rotate_window_fill_unit.sv
`timescale 1ns / 1ps
// Top of the testbench: command stimulus, rotation writes and the final verdict.
module tb_lcd_clip_rotate_window_fill_unit;
	import lcrwf_pkg::*;

	localparam int PANEL_WIDTH  = 240;
	localparam int PANEL_HEIGHT = 320;

	// register map of the configuration port
	localparam logic [2:0] ROTATION_ADDR = 3'd0;

	// mode codes the unit ignores
	localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
	localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

	localparam int RESET_CYCLES     = 10;
	localparam int SETTLE_CYCLES    = 16;  // front end may still hold a clipped command
	localparam int TAIL_CYCLES      = 40;
	localparam int RANDOM_PER_PHASE = 125;
	localparam int PHASES           = 4;

	// each phase runs under its own rotation and sender idle rate (percent)
	localparam logic [1:0] PHASE_ROT  [PHASES] = '{2'd0, 2'd3, 2'd1, 2'd2};
	localparam int         PHASE_IDLE [PHASES] = '{0, 48, 37, 0};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               start = 1'b0;
	logic               busy;
	logic [2:0]         mode = MODE_PIXEL;
	logic signed [15:0] x_pos = '0;
	logic signed [15:0] y_pos = '0;
	logic signed [15:0] span_w = '0;
	logic signed [15:0] span_h = '0;
	logic [15:0]        color = '0;
	logic               strobe;
	logic               kind;
	logic [7:0]         reg_addr;
	logic [15:0]        reg_data;
	logic [16:0]        pixel_count;
	logic               last;
	int                 errors;
	int                 pending;

	// logical screen size under the rotation last written
	logic [1:0] cur_rot = 2'd0;
	int         screen_w;
	int         screen_h;

	assign screen_w = cur_rot[0] ? PANEL_HEIGHT : PANEL_WIDTH;
	assign screen_h = cur_rot[0] ? PANEL_WIDTH : PANEL_HEIGHT;

	lcd_clip_rotate_window_fill_unit #(
		.PANEL_WIDTH (PANEL_WIDTH),
		.PANEL_HEIGHT(PANEL_HEIGHT)
	) dut (.*);

	panel_write_monitor #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT),
		.ROTATION_ADDR(ROTATION_ADDR)
	) monitor (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Present one command and hold it until the unit takes it. start stays high
	// afterwards so a following command can go out back to back.
	task automatic send_cmd(input logic [2:0] m, input logic signed [15:0] x,
			input logic signed [15:0] y, input logic signed [15:0] w,
			input logic signed [15:0] h, input logic [15:0] c);
		mode   <= m;
		x_pos  <= x;
		y_pos  <= y;
		span_w <= w;
		span_h <= h;
		color  <= c;
		start  <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	// Drop start for a random number of cycles, pct percent chance per cycle.
	task automatic sender_gap(input int pct);
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < pct);
		end
	endtask

	// Drop start and wait until every predicted item has come out.
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Write the rotation register once the unit has gone quiet.
	task automatic set_rotation(input logic [1:0] r);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= ROTATION_ADDR;
		pwdata  <= {$urandom} & ~32'h3 | 32'(r);  // junk upper bits must be ignored
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cur_rot = r;
	endtask

	// Coordinates mostly fall on the screen or within 20 of its edges; now and then any 16-bit value.
	function automatic logic signed [15:0] random_coord(input int extent);
		if ($urandom_range(7) == 0)
			return 16'($urandom);
		return 16'($urandom_range(extent + 40) - 20);
	endfunction

	// Spans: small, screen sized, non-positive, or any 16-bit value.
	function automatic logic signed [15:0] random_span(input int extent);
		case ($urandom_range(9))
			0:          return 16'($urandom);
			1:          return 16'(0 - $urandom_range(2));
			2, 3, 4, 5: return 16'($urandom_range(8, 1));
			default:    return 16'($urandom_range(extent + 20, 1));
		endcase
	endfunction

	initial begin
		int         pick;
		int         sent;
		logic [2:0] m;
		logic signed [15:0] x, y, w, h;

		// Hold reset, then release it at a clock edge.
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			set_rotation(PHASE_ROT[ph]);

			if (ph == 0) begin
				// Directed commands at rotation 0 (240 x 320 logical screen).
				send_cmd(MODE_ROTATE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0000);
				send_cmd(MODE_PIXEL, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0000);
				send_cmd(MODE_PIXEL, 16'sd239, 16'sd319, 16'sd0, 16'sd0, 16'hffff);
				// pixels just off the screen and at the extremes of the fields
				send_cmd(MODE_PIXEL, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'h1234);
				send_cmd(MODE_PIXEL, 16'sd240, 16'sd5, 16'sd0, 16'sd0, 16'h1234);
				send_cmd(MODE_PIXEL, -16'sd32768, 16'sd32767, 16'sd0, 16'sd0, 16'h8001);
				// full width line, then one that ends left of the screen
				send_cmd(MODE_HLINE, 16'sd0, 16'sd0, 16'sd240, 16'sd0, 16'ha5a5);
				send_cmd(MODE_HLINE, -16'sd32768, 16'sd10, 16'sd32767, 16'sd5, 16'h5a5a);
				// end coordinate past the int16 range; must clip, not wrap
				send_cmd(MODE_HLINE, 16'sd100, 16'sd20, 16'sd32767, -16'sd1, 16'h00ff);
				// empty lengths, then vertical lines clipped at the top and at the bottom
				send_cmd(MODE_HLINE, 16'sd5, 16'sd5, 16'sd0, 16'sd9, 16'hff00);
				send_cmd(MODE_HLINE, 16'sd5, 16'sd5, -16'sd32768, 16'sd9, 16'hff00);
				send_cmd(MODE_VLINE, 16'sd5, -16'sd10, 16'sd20, 16'sd0, 16'h0f0f);
				send_cmd(MODE_VLINE, 16'sd5, 16'sd319, 16'sd32767, 16'sd0, 16'hf0f0);
				// rectangles: fully clipped, whole screen, single pixel, corner, empty, just off the screen
				send_cmd(MODE_RECT, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
					16'h7fff);
				send_cmd(MODE_RECT, -16'sd1, -16'sd1, 16'sd32767, 16'sd32767, 16'hffff);
				send_cmd(MODE_RECT, 16'sd10, 16'sd10, 16'sd1, 16'sd1, 16'h0001);
				send_cmd(MODE_RECT, 16'sd239, 16'sd319, 16'sd5, 16'sd5, 16'h8000);
				send_cmd(MODE_RECT, 16'sd10, 16'sd10, 16'sd4, 16'sd0, 16'h4444);
				send_cmd(MODE_RECT, 16'sd10, 16'sd10, -16'sd1, 16'sd4, 16'h4444);
				send_cmd(MODE_RECT, 16'sd240, 16'sd0, 16'sd4, 16'sd4, 16'h2222);
				send_cmd(MODE_RECT, 16'sd0, 16'sd320, 16'sd4, 16'sd4, 16'h2222);
				// unused modes give nothing
				send_cmd(3'd5, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'h1111);
				send_cmd(3'd6, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'h1111);
				send_cmd(MODE_UNUSED_HI, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'h1111);
			end

			// Random commands under this phase's rotation and idle rate.
			sent = 0;
			while (sent < RANDOM_PER_PHASE) begin
				pick = $urandom_range(99);
				if (pick < 25)
					m = MODE_PIXEL;
				else if (pick < 45)
					m = MODE_HLINE;
				else if (pick < 65)
					m = MODE_VLINE;
				else if (pick < 90)
					m = MODE_RECT;
				else if (pick < 95)
					m = MODE_ROTATE;
				else
					m = 3'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
				x = random_coord(screen_w);
				y = random_coord(screen_h);
				w = random_span(m == MODE_VLINE ? screen_h : screen_w);
				h = random_span(screen_h);
				send_cmd(m, x, y, w, h, 16'($urandom));
				if (m <= MODE_ROTATE)
					sent++;
				// now and then hold the sender until the stream has fully drained
				if ($urandom_range(59) == 0)
					drain_results();
				else
					sender_gap(PHASE_IDLE[ph]);
			end
		end

		// Wait for the last items, then give stray output time to show up.
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Give up if the stream stalls or predicted items never arrive.
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule
